### sv/wfe_pkg.sv
// Shared types and constants of the wire-format field encoder.
package wfe_pkg;

   // Value encodings, as carried in req_tuser.
   typedef enum logic [2:0] {
      OP_VARINT32 = 3'd0,
      OP_VARINT64 = 3'd1,
      OP_ZIGZAG32 = 3'd2,
      OP_ZIGZAG64 = 3'd3,
      OP_FIXED32  = 3'd4,
      OP_FIXED64  = 3'd5,
      OP_BOOL     = 3'd6
   } opcode_type;

   // The one req_tuser code that is not an encoding; such an item sends nothing.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam int unsigned TAG_W    = 32;
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned REQ_DW   = 104;
   localparam int unsigned REQ_UW   = 3;
   localparam int unsigned BYTE_W   = 8;

   // Bit positions inside req_tdata.
   localparam int unsigned TAG_LSB   = 0;
   localparam int unsigned VALUE_LSB = 32;
   localparam int unsigned WTAG_BIT  = 96;
   localparam int unsigned SKIP_BIT  = 97;

endpackage

### sv/wire_field_encoder.sv
// Top level of the protocol-buffer wire-format field encoder.
//
// The encoder takes one field per item on the req_ channel and sends it out on
// the rsp_ channel as a run of bytes, one byte per item, with rsp_tlast on the
// final byte. When with_tag is set the 32-bit tag goes first as a base-128
// varint; the value follows as a varint (plain, sign-extended 32-bit, or zigzag),
// as 4 or 8 little-endian bytes, or as one bool byte. A field whose value tests
// zero while skip_if_zero is set, or one with the unused opcode, produces no
// bytes at all and is retired in the cycle it is accepted. A field that sends 1
// to 15 bytes holds the input side until its final byte is emitted; the single
// 64-bit shift register peels off one 7-bit varint group or one 8-bit fixed
// byte per cycle while the output side does not stall. The result sits in an
// output register, so the next field can be accepted while the final byte of
// the previous run still waits to be taken.
module wire_field_encoder (
   input  logic         clock,
   input  logic         reset,
   // req_tdata fields from bit 0: tag[31:0], value[63:0], with_tag,
   // skip_if_zero, then six zero pad bits.
   input  logic [103:0] req_tdata,
   // req_tuser fields from bit 0: opcode[2:0].
   input  logic [2:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rsp_tdata fields from bit 0: out_byte[7:0].
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TAG,
      ST_VALUE
   } state_type;

   state_type                      state_ff, state_in;
   logic [wfe_pkg::VALUE_W-1:0]    shift_ff, shift_in;
   logic [wfe_pkg::VALUE_W-1:0]    value_ff, value_in;
   logic                           fixed_ff, fixed_in;
   logic [2:0]                     count_ff, count_in;
   logic [wfe_pkg::BYTE_W-1:0]     byte_ff, byte_in;
   logic                           last_ff, last_in;
   logic                           valid_ff, valid_in;

   // Input field decode.
   wfe_pkg::opcode_type            opcode;
   logic [wfe_pkg::TAG_W-1:0]      tag;
   logic [wfe_pkg::VALUE_W-1:0]    value;
   logic [31:0]                    lo;
   logic                           with_tag;
   logic                           skip_if_zero;
   logic                           is_zero;
   logic                           drop;
   logic [wfe_pkg::VALUE_W-1:0]    enc;
   logic                           enc_fixed;
   logic [2:0]                     enc_count;

   // Shared byte unit.
   logic                           varint_mode;
   logic                           more;
   logic                           seg_end;
   logic [wfe_pkg::BYTE_W-1:0]     emit_byte;
   logic                           emit;
   logic                           accept;

   assign opcode       = wfe_pkg::opcode_type'(req_tuser);
   assign tag          = req_tdata[wfe_pkg::TAG_LSB +: wfe_pkg::TAG_W];
   assign value        = req_tdata[wfe_pkg::VALUE_LSB +: wfe_pkg::VALUE_W];
   assign lo           = value[31:0];
   assign with_tag     = req_tdata[wfe_pkg::WTAG_BIT];
   assign skip_if_zero = req_tdata[wfe_pkg::SKIP_BIT];

   // Work out the value as it will be sent, before any byte leaves.
   always_comb begin
      enc       = value;
      enc_fixed = 1'b0;
      enc_count = 3'd0;
      is_zero   = (value == '0);
      drop      = 1'b0;
      unique case (opcode)
         wfe_pkg::OP_VARINT32: begin
            is_zero = (lo == '0);
            enc     = {{32{lo[31]}}, lo};
         end
         wfe_pkg::OP_VARINT64: begin
            enc = value;
         end
         wfe_pkg::OP_ZIGZAG32: begin
            is_zero = (lo == '0);
            enc     = {32'd0, {lo[30:0], 1'b0} ^ {32{lo[31]}}};
         end
         wfe_pkg::OP_ZIGZAG64: begin
            enc = {value[62:0], 1'b0} ^ {64{value[63]}};
         end
         wfe_pkg::OP_FIXED32: begin
            is_zero   = (lo == '0);
            enc       = {32'd0, lo};
            enc_fixed = 1'b1;
            enc_count = 3'd3;
         end
         wfe_pkg::OP_FIXED64: begin
            enc       = value;
            enc_fixed = 1'b1;
            enc_count = 3'd7;
         end
         wfe_pkg::OP_BOOL: begin
            // A one-byte varint of 0 or 1 is exactly the bool byte.
            enc = {63'd0, ~is_zero};
         end
         default: begin
            drop = 1'b1;
         end
      endcase
      if (skip_if_zero && is_zero) begin
         drop = 1'b1;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // The tag is always a varint; the value is a varint unless it is fixed.
   assign varint_mode = (state_ff == ST_TAG) || !fixed_ff;
   assign more        = (shift_ff[wfe_pkg::VALUE_W-1:7] != '0);
   assign seg_end     = varint_mode ? !more : (count_ff == 3'd0);
   assign emit_byte   = varint_mode ? {more, shift_ff[6:0]} : shift_ff[7:0];
   assign emit        = (state_ff != ST_IDLE) && (!valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      value_in = value_ff;
      fixed_in = fixed_ff;
      count_in = count_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;

      if (accept && !drop) begin
         fixed_in = enc_fixed;
         count_in = enc_count;
         if (with_tag) begin
            shift_in = {32'd0, tag};
            value_in = enc;
            state_in = ST_TAG;
         end else begin
            shift_in = enc;
            state_in = ST_VALUE;
         end
      end

      if (emit) begin
         byte_in  = emit_byte;
         valid_in = 1'b1;
         last_in  = seg_end && (state_ff == ST_VALUE);
         shift_in = varint_mode ? (shift_ff >> 7) : (shift_ff >> 8);
         if (!varint_mode) begin
            count_in = count_ff - 3'd1;
         end
         if (seg_end) begin
            if (state_ff == ST_TAG) begin
               shift_in = value_ff;
               state_in = ST_VALUE;
            end else begin
               state_in = ST_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      shift_ff <= shift_in;
      value_ff <= value_in;
      fixed_ff <= fixed_in;
      count_ff <= count_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tvalid = valid_ff;

endmodule

### sv/wfe_checker.sv
// Port-level assertions for the wire-format field encoder, bound to its top level.
module wfe_checker (
   input logic         clock,
   input logic         reset,
   input logic [103:0] req_tdata,
   input logic [2:0]   req_tuser,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [7:0]   rsp_tdata,
   input logic         rsp_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   logic fire;
   logic emits;
   logic skipped64;

   assign fire  = req_tvalid && req_tready;
   // Any field with a real opcode and no skip request sends at least one byte.
   assign emits = (req_tuser != wfe_pkg::OP_UNUSED) && !req_tdata[wfe_pkg::SKIP_BIT];
   assign skipped64 = (req_tuser == wfe_pkg::OP_VARINT64) && req_tdata[wfe_pkg::SKIP_BIT]
                      && (req_tdata[wfe_pkg::VALUE_LSB +: wfe_pkg::VALUE_W] == '0);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_busy_after_field: assert property (@(posedge clock) disable iff (reset)
      fire && emits |=> !req_tready)
      else $error("input taken again before the run of a field was sent");

   a_skip_retires: assert property (@(posedge clock) disable iff (reset)
      fire && (skipped64 || req_tuser == wfe_pkg::OP_UNUSED) |=> req_tready)
      else $error("suppressed field kept the input side busy");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("encoder not idle after reset");

endmodule

bind wire_field_encoder wfe_checker u_wfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
